// ===== rtl/core/tcprlt_pkg.sv =====
// Shared types and constants for the TCP reorder lateness tracker.
// Holds the table geometry, the item structs and the controller/datapath links.
// No dependencies.
package tcprlt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SEQ_BITS    = 32;
  localparam int unsigned PTR_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LATE_W      = 6;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LOST = CFG_IDX_W'(1);

  localparam logic [LATE_W-1:0] MAX_LATE_RESET    = LATE_W'(8);
  localparam logic              REPORT_LOST_RESET = 1'b1;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] expected;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [LATE_W-1:0]   lateness;
    logic [SEQ_BITS-1:0] next_expected;
    logic                lost;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] expected;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic insert;      // append the incoming item
    logic start;       // latch lookup key, clear position
    logic rd_scan;     // read the entry at the current position
    logic scan_next;   // advance the position
    logic hit_capture; // record a hit at the current position
    logic miss_capture;
    logic pop_head;    // remove the oldest entry
    logic rd_shift;    // read the entry after the current position
    logic wr_shift;    // write it one place down, advance
    logic shrink;      // drop the youngest slot after a shift
    logic out_load;    // move the held result to the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_ok;     // position is inside both table and window
    logic hit;         // read entry matches the key
    logic pos_zero;
    logic shift_more;  // an entry younger than the position remains
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/tcprlt_ctrl.sv =====
// Sequencer for the TCP reorder lateness tracker.
// Steps inserts, window scans, gap closing and result hand-off; uses tcprlt_pkg.
module tcprlt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_action_i,
  output logic                  in_ready_o,
  input  tcprlt_pkg::ctrl_sts_t sts_i,
  output tcprlt_pkg::ctrl_cmd_t cmd_o
);
  import tcprlt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_INSERT) begin
            cmd_o.insert = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_ok) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = ST_CMP;
        end else begin
          cmd_o.miss_capture = 1'b1;
          state_d            = ST_RESULT;
        end
      end
      ST_CMP: begin
        if (sts_i.hit) begin
          cmd_o.hit_capture = 1'b1;
          if (sts_i.pos_zero) begin
            cmd_o.pop_head = 1'b1;
            state_d        = ST_RESULT;
          end else begin
            state_d = ST_SHIFT_RD;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_shift = 1'b1;
          state_d        = ST_SHIFT_WR;
        end else begin
          cmd_o.shrink = 1'b1;
          state_d      = ST_RESULT;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = ST_SHIFT_RD;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tcprlt_dpath.sv =====
// Datapath for the TCP reorder lateness tracker: circular entry memory,
// head and fill count, scan position, config registers and output register.
// Uses tcprlt_pkg; driven by tcprlt_ctrl.
module tcprlt_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcprlt_pkg::in_item_t              in_data_i,
  input  tcprlt_pkg::ctrl_cmd_t             cmd_i,
  output tcprlt_pkg::ctrl_sts_t             sts_o,
  input  logic                              cfg_we_i,
  input  logic [tcprlt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcprlt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcprlt_pkg::out_item_t             out_data_o
);
  import tcprlt_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = ((CNT_W > LATE_W) ? CNT_W : LATE_W) + 1;

  function automatic logic [PTR_W-1:0] wrap_addr(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'(TABLE_DEPTH);
    if (sum >= lim) begin
      return PTR_W'(sum - lim);
    end
    return PTR_W'(sum);
  endfunction

  entry_t              mem [TABLE_DEPTH];
  entry_t              rdata_q;
  logic [PTR_W-1:0]    head_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    pos_q;
  logic [SEQ_BITS-1:0] key_q;
  logic [LATE_W-1:0]   max_late_q;
  logic                report_lost_q;
  out_item_t           res_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic                full;
  logic [SUM_W-1:0]    head_ext;
  logic [SUM_W-1:0]    pos_ext;
  logic [PTR_W-1:0]    pos_addr;
  logic [PTR_W-1:0]    next_addr;
  logic [PTR_W-1:0]    tail_addr;
  logic [PTR_W-1:0]    head_inc;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [PTR_W-1:0]    mem_raddr;

  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign head_ext  = SUM_W'(head_q);
  assign pos_ext   = SUM_W'(pos_q);
  assign pos_addr  = wrap_addr(head_ext + pos_ext);
  assign next_addr = wrap_addr(head_ext + pos_ext + SUM_W'(1));
  assign tail_addr = full ? head_q : wrap_addr(head_ext + SUM_W'(count_q));
  assign head_inc  = wrap_addr(head_ext + SUM_W'(1));

  // Single write port, single registered read port.
  assign mem_we    = cmd_i.insert | cmd_i.wr_shift;
  assign mem_waddr = cmd_i.insert ? tail_addr : pos_addr;
  assign mem_wdata = cmd_i.insert ? entry_t'{seq: in_data_i.seq, expected: in_data_i.expected}
                                  : rdata_q;
  assign mem_re    = cmd_i.rd_scan | cmd_i.rd_shift;
  assign mem_raddr = cmd_i.rd_shift ? next_addr : pos_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign sts_o.scan_ok    = (pos_q < count_q) && (CMP_W'(pos_q) <= CMP_W'(max_late_q));
  assign sts_o.hit        = (rdata_q.seq == key_q);
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.shift_more = ((pos_ext + SUM_W'(1)) < SUM_W'(count_q));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Table pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.insert) begin
        if (full) begin
          head_q <= head_inc;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (cmd_i.pop_head) begin
        head_q  <= head_inc;
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.shrink) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Scan position doubles as the shift cursor after a hit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q <= '0;
      key_q <= in_data_i.seq;
    end else if (cmd_i.scan_next || cmd_i.wr_shift) begin
      pos_q <= pos_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_capture) begin
      res_q.found         <= 1'b1;
      res_q.lateness      <= LATE_W'(pos_q);
      res_q.next_expected <= rdata_q.expected;
      res_q.lost          <= 1'b0;
    end else if (cmd_i.miss_capture) begin
      res_q.found         <= 1'b0;
      res_q.lateness      <= '0;
      res_q.next_expected <= '0;
      res_q.lost          <= report_lost_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_late_q    <= MAX_LATE_RESET;
      report_lost_q <= REPORT_LOST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_LATE:    max_late_q    <= cfg_data_i[LATE_W-1:0];
        CFG_REPORT_LOST: report_lost_q <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert && !full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert into non-full table did not grow count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_shift_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_shift |-> (pos_ext + SUM_W'(1)) < SUM_W'(count_q))
    else $error("shift write outside live entries");

endmodule

// ===== rtl/core/tcp_reorder_lateness_tracker.sv =====
// Top level of the TCP reorder lateness tracker.
// Joins tcprlt_ctrl and tcprlt_dpath; uses tcprlt_pkg.
//
// Keeps up to TABLE_DEPTH pending segments in arrival order in a circular
// single-port-write, single-port-read memory. An insert transfer (action 0)
// drops the oldest entry when the table is full. A lookup transfer
// (action 1) probes positions from the oldest entry up to max_late, each
// probe a memory read and then a compare. A hit at the oldest position just
// advances the head; a hit at position p > 0 closes the gap by moving the
// n-p-1 younger entries down, each by a read and a write back. The result
// then moves to the output register. No new transfer is taken until a lookup
// has placed its result; a result waiting in the output register does not
// hold off the next transfer. Configuration writes are always taken (ready
// stays high); unknown register indexes are ignored.
module tcp_reorder_lateness_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tcprlt_pkg::in_item_t              in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcprlt_pkg::out_item_t             out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcprlt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcprlt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tcprlt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  tcprlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcprlt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tcp_reorder_lateness_tracker_tb.sv =====
// Self-checking testbench for tcp_reorder_lateness_tracker.
// Drives segment inserts, lookups and register writes, and checks each result against
// an in-bench table model. Depends on tcprlt_pkg and the RTL only.
module tcp_reorder_lateness_tracker_tb;
  import tcprlt_pkg::*;

  localparam int DRAIN_CYC   = 300;     // worst lookup: full scan plus full gap close
  localparam int HOLD_CYC    = 400;     // long output hold-off during the squeeze phase
  localparam int MAX_REPORTS = 40;
  localparam int LIMIT_CYC   = 900_000;
  localparam logic [SEQ_BITS-1:0] POOL_BASE = 32'h0000_1000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: an item or a register write, with an
  // optional hand-typed result.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Model of the pending-segment table, oldest first, and the lookup results
  // still owed by the block.
  entry_t    pending_segs[$];
  out_item_t expected_reports[$];
  logic [LATE_W-1:0] win_late  = MAX_LATE_RESET;
  logic              flag_lost = REPORT_LOST_RESET;

  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic hold_req     = 1'b0;
  int   mismatch_cnt = 0;
  int   sent_cnt     = 0;
  int   lookup_cnt   = 0;
  int   result_cnt   = 0;
  int   hit_cnt      = 0;
  int   deepest      = 0;

  dir_row_t dir_rows[$];

  tcp_reorder_lateness_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one accepted transfer to the table model; queue the result a lookup owes.
  function automatic void track_segment(input in_item_t it);
    entry_t    ent;
    out_item_t res;
    int        p;
    logic      hit;
    sent_cnt++;
    if (it.action == ACT_INSERT) begin
      // Full table: drop the oldest entry before appending.
      if (pending_segs.size() >= TABLE_DEPTH) void'(pending_segs.pop_front());
      ent.seq      = it.seq;
      ent.expected = it.expected;
      pending_segs.push_back(ent);
    end else begin
      lookup_cnt++;
      res = '0;
      hit = 1'b0;
      p   = 0;
      // Scan from the oldest entry, but only up to max_late positions deep.
      while (!hit && p < pending_segs.size() && p <= int'(win_late)) begin
        ent = pending_segs[p];
        if (ent.seq == it.seq) hit = 1'b1;
        else p++;
      end
      if (hit) begin
        res.found         = 1'b1;
        res.lateness      = p[LATE_W-1:0];
        res.next_expected = ent.expected;
        pending_segs.delete(p);
      end else begin
        res.lost = flag_lost;
      end
      expected_reports.push_back(res);
    end
  endfunction

  // Draw a random item: a mix of fresh and pooled sequence numbers so that
  // duplicates occur, with most lookups aimed at entries near the window.
  function automatic in_item_t next_item(input int ins_pct);
    in_item_t it;
    entry_t   ent;
    int       span;
    it.expected = $urandom;
    if (pending_segs.size() == 0 || $urandom_range(0, 99) < ins_pct) begin
      it.action = ACT_INSERT;
      it.seq    = $urandom_range(0, 1) ? $urandom : POOL_BASE + $urandom_range(0, 15);
    end else begin
      it.action = ACT_LOOKUP;
      if ($urandom_range(0, 3) != 0) begin
        // Reach a little past the window so some present segments still miss.
        span = pending_segs.size() - 1;
        if (span > int'(win_late) + 2) span = int'(win_late) + 2;
        ent    = pending_segs[$urandom_range(0, span)];
        it.seq = ent.seq;
      end else begin
        it.seq = $urandom_range(0, 1) ? $urandom : POOL_BASE + $urandom_range(0, 15);
      end
    end
    return it;
  endfunction

  function automatic dir_row_t seg_row(input logic act, input logic [SEQ_BITS-1:0] s,
                                       input logic [SEQ_BITS-1:0] e);
    dir_row_t r;
    r = '0;
    r.kind          = ROW_ITEM;
    r.item.action   = act;
    r.item.seq      = s;
    r.item.expected = e;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [SEQ_BITS-1:0] s, input logic f,
                                       input logic [LATE_W-1:0] l,
                                       input logic [SEQ_BITS-1:0] nx, input logic lo);
    dir_row_t r;
    r = seg_row(ACT_LOOKUP, s, ~s);
    r.typed              = 1'b1;
    r.want.found         = f;
    r.want.lateness      = l;
    r.want.next_expected = nx;
    r.want.lost          = lo;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] i,
                                       input logic [CFG_DATA_W-1:0] d);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = i;
    r.data = d;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] result %0d %s: got %h, want %h", $time, result_cnt, what, got, want);
  endtask

  // Offer one transfer; hold valid and payload until the block takes it.
  task automatic offer(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    track_segment(it);
  endtask

  // Write a register once the block is idle: no result owed and the last
  // insert given time to settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // Unknown indexes leave both registers alone.
    if (idx == CFG_MAX_LATE) win_late = val[LATE_W-1:0];
    else if (idx == CFG_REPORT_LOST) flag_lost = val[0];
  endtask

  task automatic run_phase(input logic [LATE_W-1:0] late, input logic lost_on, input int idle,
                           input int stall, input int n_items, input logic squeeze);
    int k;
    // Junk in the upper data bits must be masked off by the block.
    write_reg(CFG_MAX_LATE, (32'($urandom) & 32'hFFFF_FFC0) | 32'(late));
    write_reg(CFG_REPORT_LOST, (32'($urandom) & 32'hFFFF_FFFE) | 32'(lost_on));
    idle_pct  = idle;
    stall_pct = stall;
    // Squeeze: block the output for a long stretch while lookups keep coming.
    if (squeeze) hold_req = 1'b1;
    for (k = 0; k < n_items; k++) offer(next_item(squeeze ? 25 : 50));
  endtask

  // Output side: random back-pressure, plus the long hold-off on request.
  initial begin : rx_side
    int hold_left;
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Compare every result transfer against the oldest owed result.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_cnt++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("arrived with none pending", 32'(out_data_o.next_expected), '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_data_o.found !== want.found)
          flag_mismatch("found", 32'(out_data_o.found), 32'(want.found));
        if (out_data_o.lateness !== want.lateness)
          flag_mismatch("lateness", 32'(out_data_o.lateness), 32'(want.lateness));
        if (out_data_o.next_expected !== want.next_expected)
          flag_mismatch("next_expected", out_data_o.next_expected, want.next_expected);
        if (out_data_o.lost !== want.lost)
          flag_mismatch("lost", 32'(out_data_o.lost), 32'(want.lost));
        if (want.found) begin
          hit_cnt++;
          if (int'(want.lateness) > deepest) deepest = int'(want.lateness);
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYC * 12);
    $display("tcp_reorder_lateness_tracker regression: fail");
    $finish;
  end

  initial begin : stimulus
    dir_row_t             row;
    in_item_t             it;
    entry_t               ent;
    logic [SEQ_BITS-1:0]  first_seq;
    int                   k;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;

    // Directed table, starting from the reset settings (window 8, lost on).
    dir_rows.push_back(chk_row(32'h0000_0000, 1'b0, 6'd0, 32'h0, 1'b1)); // empty table
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h0000_0000, 32'h0000_0000));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(chk_row(32'hFFFF_FFFF, 1'b1, 6'd1, 32'hFFFF_FFFF, 1'b0));
    dir_rows.push_back(chk_row(32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, 1'b0));
    // Duplicate sequence: the oldest copy goes first.
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h0000_0007, 32'h0000_0011));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h0000_0007, 32'h0000_0022));
    dir_rows.push_back(chk_row(32'h0000_0007, 1'b1, 6'd0, 32'h0000_0011, 1'b0));
    dir_rows.push_back(chk_row(32'h0000_0007, 1'b1, 6'd0, 32'h0000_0022, 1'b0));
    // Window of zero: a present segment one place deep is still a miss.
    dir_rows.push_back(cfg_row(CFG_MAX_LATE, 32'hFFFF_FFC0));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h0000_000A, 32'h0000_0001));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h0000_000B, 32'h0000_0002));
    dir_rows.push_back(chk_row(32'h0000_000B, 1'b0, 6'd0, 32'h0, 1'b1));
    dir_rows.push_back(cfg_row(CFG_REPORT_LOST, 32'hFFFF_FFFE));
    dir_rows.push_back(chk_row(32'h5555_5555, 1'b0, 6'd0, 32'h0, 1'b0));
    // Unknown register index: must change nothing.
    dir_rows.push_back(cfg_row(8'hFF, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_MAX_LATE, 32'h0000_003F));
    dir_rows.push_back(chk_row(32'h0000_000B, 1'b1, 6'd1, 32'h0000_0002, 1'b0));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555));
    dir_rows.push_back(seg_row(ACT_INSERT, 32'h5555_5555, 32'hAAAA_AAAA));
    dir_rows.push_back(seg_row(ACT_LOOKUP, 32'h5555_5555, 32'h0));
    dir_rows.push_back(seg_row(ACT_LOOKUP, 32'h0000_000A, 32'h0));
    dir_rows.push_back(seg_row(ACT_LOOKUP, 32'hAAAA_AAAA, 32'h0));
    dir_rows.push_back(cfg_row(CFG_REPORT_LOST, 32'h0000_0001));
    dir_rows.push_back(chk_row(32'h1234_5678, 1'b0, 6'd0, 32'h0, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_rows.size(); k++) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        offer(row.item);
        // Replace the computed result with the hand-typed one.
        if (row.typed) begin
          void'(expected_reports.pop_back());
          expected_reports.push_back(row.want);
        end
      end
    end

    // Overfill: push past full so the oldest entries drop, then hit the
    // youngest entry at the deepest position and look for the dropped one.
    write_reg(CFG_MAX_LATE, 32'(63));
    first_seq = '0;
    for (k = 0; k < TABLE_DEPTH + 2; k++) begin
      it.action   = ACT_INSERT;
      it.seq      = $urandom;
      it.expected = $urandom;
      if (k == 0) first_seq = it.seq;
      offer(it);
    end
    ent         = pending_segs[TABLE_DEPTH-1];
    it.action   = ACT_LOOKUP;
    it.seq      = ent.seq;
    it.expected = $urandom;
    offer(it);
    it.seq = first_seq;
    offer(it);

    // Random phases: window, lost reporting, idle and stall mixes.
    run_phase(6'd8,  1'b1, 0,  0,  60, 1'b0);
    run_phase(6'd0,  1'b0, 68, 0,  55, 1'b0);
    run_phase(6'd63, 1'b1, 0,  68, 55, 1'b0);
    run_phase(6'd31, 1'b0, 12, 12, 55, 1'b0);
    run_phase(6'd5,  1'b1, 0,  0,  50, 1'b1);
    run_phase(6'd2,  1'b1, 12, 12, 40, 1'b0);

    // Drain: stop offering, wait for owed results, then watch for strays.
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d transfers (%0d lookups), %0d results checked, %0d hits, deepest %0d",
             sent_cnt, lookup_cnt, result_cnt, hit_cnt, deepest);
    $display("windows 0 to 63, lost reporting on and off, table overflow, long output hold-off");
    if (mismatch_cnt == 0) begin
      $display("tcp_reorder_lateness_tracker regression: pass");
    end else begin
      $display("tcp_reorder_lateness_tracker regression: fail");
    end
    $finish;
  end

endmodule
